FILE: hw/rtl/ipv4_blocklist_table_macros.svh
// assertion macros for the ipv4 blocklist table
`ifndef IPV4_BLOCKLIST_TABLE_MACROS_SVH
`define IPV4_BLOCKLIST_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define IPBL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IPBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IPBL_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPBL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/ipbl_pkg.sv
// shared request codes and state encoding for the ipv4 blocklist table
package ipbl_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  localparam int ADDR_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

FILE: hw/rtl/ipbl_ram.sv
// generic single-clock ram, one write port and one registered read port
module ipbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/ipv4_blocklist_table.sv
// top level of the ipv4 blocklist table: scan sequencer, valid bits and address ram
//
//  channel  | handshake              | ports
//  ---------+------------------------+--------------------------------------------
//  request  | start && !busy accepts | in_req_type, in_ip_address
//  result   | out_valid, one cycle   | out_block_connection, out_add_dropped
//
// every request walks the address ram one entry per cycle through its single read
// port; the result strobe is registered from the compare at the last entry, or at the
// first match or free entry for an add, and a new request can be taken while it is high
// reset empties the table at once: the valid bits are flip-flops, the ram needs no pass
// busy stays high from acceptance until the result strobe; the receiver cannot stall,
// so each result word is shown for exactly one cycle
`include "ipv4_blocklist_table_macros.svh"

module ipv4_blocklist_table
  import ipbl_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [ADDR_W-1:0] in_ip_address,
  output logic              out_valid,
  output logic              out_block_connection,
  output logic              out_add_dropped
);

  // index into the table and a counter that can also hold ENTRIES itself
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ENT_CNT  = CW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  // request word held for the whole scan
  logic [1:0]        req_r;
  logic [ADDR_W-1:0] addr_r;

  // read issue counter and compare stage (in the cycle after each read, matching the registered ram read)
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          block_r, block_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_block_r, out_block_nxt;
  logic out_drop_r, out_drop_nxt;

  logic              accept;
  logic              rd_issue;
  logic [ADDR_W-1:0] rd_data;
  logic              hit;
  logic              free_slot;
  logic              add_stop;
  logic              last_cmp;
  logic              fin;
  logic              ram_we;

  assign accept = start && !busy;

  // an entry matches only when valid, so unwritten ram contents never leak out
  assign hit       = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data == addr_r);
  assign free_slot = cmp_vld_r && !valid_r[cmp_idx_r];
  assign add_stop  = (req_r == REQ_ADD) && (hit || free_slot);
  assign last_cmp  = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign fin       = (state_r == ST_SCAN) && (add_stop || last_cmp);

  // keep issuing reads until every entry has been requested or the scan ends
  assign rd_issue = (state_r == ST_SCAN) && (rd_idx_r < ENT_CNT) && !fin;

  // add stores the address in the first free entry it meets
  assign ram_we = (state_r == ST_SCAN) && (req_r == REQ_ADD) && !hit && free_slot;

  ipbl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (ENTRIES)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cmp_idx_r),
    .wr_data (addr_r),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    block_nxt     = block_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_block_nxt = out_block_r;
    out_drop_nxt  = out_drop_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_SCAN;
          rd_idx_nxt = '0;
          block_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        // read stage
        if (rd_issue) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IW-1:0];
        end
        // compare stage
        if (hit && (req_r == REQ_CHECK)) begin
          block_nxt = 1'b1;
        end
        if (hit && (req_r == REQ_REMOVE)) begin
          valid_nxt[cmp_idx_r] = 1'b0;
        end
        if (ram_we) begin
          valid_nxt[cmp_idx_r] = 1'b1;
        end
        if (fin) begin
          state_nxt     = ST_IDLE;
          cmp_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_block_nxt = (req_r == REQ_CHECK) && (block_r || hit);
          // ran off the end with neither a match nor a free entry
          out_drop_nxt  = (req_r == REQ_ADD) && !add_stop;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      addr_r <= in_ip_address;
    end
    cmp_idx_r   <= cmp_idx_nxt;
    block_r     <= block_nxt;
    out_block_r <= out_block_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_block_connection = out_block_r;
  assign out_add_dropped      = out_drop_r;

  // a result word only ever closes a scan
  `IPBL_ASSERT(a_result_after_scan, clk, rst_n, out_valid |-> $past(busy), "stray result")
  // an accepted request always raises busy on the next cycle
  `IPBL_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> busy, "accept without busy")
  // a result never reports both a block and a dropped add
  `IPBL_ASSERT(a_one_flag, clk, rst_n, out_valid |-> !(out_block_r && out_drop_r), "both flags")
  // the table never changes while no request is being scanned
  `IPBL_ASSERT(a_valid_quiet, clk, rst_n, $past(!busy && rst_n) |-> $stable(valid_r), "idle edit")

endmodule
